// ===== sv/loab_pkg.sv =====
// Shared types and constants for the logo overlay alpha blend block.
// No dependencies; every other file of the block imports this package.
package loab_pkg;

    localparam int ID_W        = 32;
    localparam int WIN_W       = 16;
    localparam int PIX_W       = 8;
    localparam int FRAC_BITS   = 16;
    localparam int QUOT_W      = FRAC_BITS + 1;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [PIX_W-1:0] OPAQUE_MAX = {PIX_W{1'b1}};

    typedef enum logic [2:0] {
        CFG_RANGE_START     = 3'd0,
        CFG_RANGE_END       = 3'd1,
        CFG_FADE_IN_FRAMES  = 3'd2,
        CFG_FADE_OUT_FRAMES = 3'd3,
        CFG_YUV_MODE        = 3'd4,
        CFG_GRAY_OUT        = 3'd5
    } cfg_index_t;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_PIXEL = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_FADE,
        BK_MIX,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic             command;
        logic [ID_W-1:0]  frame_id;
        logic [PIX_W-1:0] video_c0;
        logic [PIX_W-1:0] video_c1;
        logic [PIX_W-1:0] video_c2;
        logic [PIX_W-1:0] logo_c0;
        logic [PIX_W-1:0] logo_c1;
        logic [PIX_W-1:0] logo_c2;
        logic [PIX_W-1:0] opacity;
        logic             chroma_site;
    } loab_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_c0;
        logic [PIX_W-1:0] out_c1;
        logic [PIX_W-1:0] out_c2;
        logic             frame_active;
    } loab_out_t;

    typedef struct packed {
        logic [ID_W-1:0]  range_start;
        logic [ID_W-1:0]  range_end;
        logic [WIN_W-1:0] fade_in_frames;
        logic [WIN_W-1:0] fade_out_frames;
        logic             yuv_mode;
        logic             gray_out;
    } loab_cfg_t;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        logic             is_frame;
        logic             in_range;
        logic             fade;
        logic [WIN_W-1:0] num;
        logic [WIN_W-1:0] den;
        logic [PIX_W-1:0] video_c0;
        logic [PIX_W-1:0] video_c1;
        logic [PIX_W-1:0] video_c2;
        logic [PIX_W-1:0] logo_c0;
        logic [PIX_W-1:0] logo_c1;
        logic [PIX_W-1:0] logo_c2;
        logic [PIX_W-1:0] opacity;
        logic             chroma_site;
    } loab_entry_t;

endpackage

// ===== sv/loab_front.sv =====
// Front end: input register and item classification (range test, fade window).
// Depends on loab_pkg.
module loab_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  loab_pkg::loab_in_t  s_data,
    input  loab_pkg::loab_cfg_t cfg,
    input  logic                q_full,
    output logic                q_push,
    output loab_pkg::loab_entry_t q_wdata
);
    import loab_pkg::*;

    logic        hold_valid_reg, hold_valid_next;
    loab_in_t    hold_reg, hold_next;
    logic [ID_W:0] diff_in, diff_out;
    logic [ID_W-1:0] d_in, d_out;
    logic        in_range, hit_in, hit_out;

    assign q_push  = hold_valid_reg && !q_full;
    assign s_ready = !hold_valid_reg || !q_full;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (q_push) begin
            hold_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            hold_valid_next = 1'b1;
            hold_next       = s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_reg <= hold_next;
    end

    // The borrows of the two distances double as the range test.
    always_comb begin
        diff_in  = {1'b0, hold_reg.frame_id} - {1'b0, cfg.range_start};
        diff_out = {1'b0, cfg.range_end} - {1'b0, hold_reg.frame_id};
        d_in     = diff_in[ID_W-1:0];
        d_out    = diff_out[ID_W-1:0];
        in_range = !diff_in[ID_W] && !diff_out[ID_W];
        hit_in   = in_range && (d_in[ID_W-1:WIN_W] == '0)
                   && (d_in[WIN_W-1:0] < cfg.fade_in_frames);
        hit_out  = in_range && !hit_in && (d_out[ID_W-1:WIN_W] == '0)
                   && (d_out[WIN_W-1:0] < cfg.fade_out_frames);

        q_wdata.is_frame    = (hold_reg.command == CMD_FRAME);
        q_wdata.in_range    = in_range;
        q_wdata.fade        = hit_in || hit_out;
        q_wdata.num         = hit_in ? (cfg.fade_in_frames - d_in[WIN_W-1:0])
                                     : (cfg.fade_out_frames - d_out[WIN_W-1:0]);
        q_wdata.den         = hit_in ? cfg.fade_in_frames : cfg.fade_out_frames;
        q_wdata.video_c0    = hold_reg.video_c0;
        q_wdata.video_c1    = hold_reg.video_c1;
        q_wdata.video_c2    = hold_reg.video_c2;
        q_wdata.logo_c0     = hold_reg.logo_c0;
        q_wdata.logo_c1     = hold_reg.logo_c1;
        q_wdata.logo_c2     = hold_reg.logo_c2;
        q_wdata.opacity     = hold_reg.opacity;
        q_wdata.chroma_site = hold_reg.chroma_site;
    end

endmodule

// ===== sv/loab_fifo.sv =====
// Short first-in first-out queue of classified items between front and back end.
// Depends on loab_pkg.
module loab_fifo #(
    parameter int DEPTH = loab_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  loab_pkg::loab_entry_t wdata,
    output logic                  full,
    input  logic                  pop,
    output loab_pkg::loab_entry_t rdata,
    output logic                  empty
);
    import loab_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    loab_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/loab_div.sv =====
// Serial restoring divider for the fade factor, one quotient bit per cycle.
// Depends on loab_pkg.
module loab_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [loab_pkg::WIN_W-1:0]      num,
    input  logic [loab_pkg::WIN_W-1:0]      den,
    output logic                            done,
    output logic [loab_pkg::QUOT_W-1:0]     quot
);
    import loab_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WIN_W:0]    rem_reg, rem_next;
    logic [WIN_W-1:0]  den_reg, den_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              ge;
    logic [WIN_W:0]    diff;

    assign done = done_reg;
    assign quot = quot_reg;

    // The numerator never exceeds the divisor, so the remainder stays below
    // twice the divisor and one compare and subtract settles each bit.
    always_comb begin
        ge        = (rem_reg >= {1'b0, den_reg});
        diff      = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUOT_W);
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = {diff[WIN_W-1:0], 1'b0};
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

endmodule

// ===== sv/loab_back.sv =====
// Back end: frame state, opacity fade, component blend and the output register.
// Depends on loab_pkg; drives the fade divider loab_div from the top level.
module loab_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  loab_pkg::loab_cfg_t           cfg,
    input  logic                          q_empty,
    input  loab_pkg::loab_entry_t         q_rdata,
    output logic                          q_pop,
    output logic                          div_start,
    output logic [loab_pkg::WIN_W-1:0]    div_num,
    output logic [loab_pkg::WIN_W-1:0]    div_den,
    input  logic                          div_done,
    input  logic [loab_pkg::QUOT_W-1:0]   div_quot,
    output logic                          m_valid,
    input  logic                          m_ready,
    output loab_pkg::loab_out_t           m_data
);
    import loab_pkg::*;

    localparam int PROD_W = 2 * PIX_W;
    localparam int FADE_W = PIX_W + QUOT_W;

    back_state_t       state_reg, state_next;
    loab_entry_t       cur_reg, cur_next;
    logic              in_range_reg, in_range_next;
    logic              fade_en_reg, fade_en_next;
    logic [QUOT_W-1:0] factor_reg, factor_next;
    logic [PIX_W-1:0]  opa_reg, opa_next;
    logic [PROD_W-1:0] pv_reg [3];
    logic [PROD_W-1:0] pv_next [3];
    logic [PROD_W-1:0] pl_reg [3];
    logic [PROD_W-1:0] pl_next [3];
    logic              out_valid_reg, out_valid_next;
    loab_out_t         out_reg, out_next;
    logic [FADE_W-1:0] fade_prod;
    logic [PIX_W-1:0]  inv_opa;
    logic [PIX_W-1:0]  mix [3];
    logic              do_chroma;
    loab_out_t         result;

    // floor(x / 255) for any 16-bit product of two 8-bit values.
    function automatic logic [PIX_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + {{(PIX_W + 1){1'b0}}, x[PROD_W-1:PIX_W]} + 1'b1;
        return s[PROD_W-1:PIX_W];
    endfunction

    assign div_num = q_rdata.num;
    assign div_den = q_rdata.den;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        fade_prod = FADE_W'(OPAQUE_MAX - cur_reg.opacity) * FADE_W'(factor_reg);
        inv_opa   = OPAQUE_MAX - opa_reg;
        for (int i = 0; i < 3; i++) begin
            mix[i] = div255(pv_reg[i]) + div255(pl_reg[i]);
        end
        do_chroma = !cfg.yuv_mode || (cur_reg.chroma_site && !cfg.gray_out);

        result.frame_active = in_range_reg;
        if (cur_reg.is_frame) begin
            result.out_c0 = '0;
            result.out_c1 = '0;
            result.out_c2 = '0;
        end else if (!in_range_reg) begin
            result.out_c0 = cur_reg.video_c0;
            result.out_c1 = cur_reg.video_c1;
            result.out_c2 = cur_reg.video_c2;
        end else begin
            result.out_c0 = mix[0];
            result.out_c1 = do_chroma ? mix[1] : cur_reg.video_c1;
            result.out_c2 = do_chroma ? mix[2] : cur_reg.video_c2;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        in_range_next  = in_range_reg;
        fade_en_next   = fade_en_reg;
        factor_next    = factor_reg;
        opa_next       = opa_reg;
        pv_next        = pv_reg;
        pl_next        = pl_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cur_next = q_rdata;
                    if (!q_rdata.is_frame) begin
                        state_next = BK_FADE;
                    end else if (q_rdata.fade) begin
                        div_start  = 1'b1;
                        state_next = BK_DIV;
                    end else begin
                        in_range_next = q_rdata.in_range;
                        fade_en_next  = 1'b0;
                        factor_next   = '0;
                        state_next    = BK_EMIT;
                    end
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    in_range_next = cur_reg.in_range;
                    fade_en_next  = 1'b1;
                    factor_next   = div_quot;
                    state_next    = BK_EMIT;
                end
            end
            BK_FADE: begin
                // The faded term never exceeds 255 - opacity, so no clamp.
                if (fade_en_reg) begin
                    opa_next = cur_reg.opacity + fade_prod[FRAC_BITS +: PIX_W];
                end else begin
                    opa_next = cur_reg.opacity;
                end
                state_next = BK_MIX;
            end
            BK_MIX: begin
                pv_next[0] = PROD_W'(cur_reg.video_c0) * PROD_W'(opa_reg);
                pv_next[1] = PROD_W'(cur_reg.video_c1) * PROD_W'(opa_reg);
                pv_next[2] = PROD_W'(cur_reg.video_c2) * PROD_W'(opa_reg);
                pl_next[0] = PROD_W'(cur_reg.logo_c0) * PROD_W'(inv_opa);
                pl_next[1] = PROD_W'(cur_reg.logo_c1) * PROD_W'(inv_opa);
                pl_next[2] = PROD_W'(cur_reg.logo_c2) * PROD_W'(inv_opa);
                state_next = BK_EMIT;
            end
            BK_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_next       = result;
                    state_next     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            in_range_reg  <= 1'b0;
            fade_en_reg   <= 1'b0;
            factor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_range_reg  <= in_range_next;
            fade_en_reg   <= fade_en_next;
            factor_reg    <= factor_next;
            out_valid_reg <= out_valid_next;
        end
        cur_reg <= cur_next;
        opa_reg <= opa_next;
        pv_reg  <= pv_next;
        pl_reg  <= pl_next;
        out_reg <= out_next;
    end

endmodule

// ===== sv/logo_overlay_alpha_blend_fade.sv =====
// Top level of the logo overlay alpha blend block with frame-range fade.
// Depends on loab_pkg, loab_front, loab_fifo, loab_div and loab_back.
//
// Usage: items enter on the s_ channel (valid/ready, payload s_data). A frame
// start item tests its id against the rendering range and sets the fade
// factor; a pixel item blends the logo onto the video. Every item gives
// exactly one result transfer on the m_ channel (valid/ready, payload m_data).
// The cfg channel writes one register per transfer; cfg_ready is always high,
// and writes are expected only while the block is idle.
// A pixel passes the input register, the queue and the back-end idle, fade,
// mix and emit states before it reaches the output register and m_valid.
// The back-end sequencer takes one pixel at a time and runs the fade multiply,
// the blend products and the divide-by-255 in turn. A frame start without fade
// goes straight from the idle to the emit state; one with fade holds the back
// end while the serial divider produces one quotient bit per cycle.
// A four-entry queue between front and back end lets input transfers continue
// while the back end is busy or the receiver stalls; a stalled result simply
// waits in the output register. Reset clears the registers to their defaults,
// empties the queue and clears the frame state, so pixels pass through until
// the first frame start.
module logo_overlay_alpha_blend_fade #(
    parameter int QUEUE_DEPTH = loab_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  loab_pkg::loab_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output loab_pkg::loab_out_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  loab_pkg::cfg_index_t              cfg_index,
    input  logic [loab_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import loab_pkg::*;

    loab_cfg_t         cfg_reg, cfg_next;
    loab_entry_t       q_wdata, q_rdata;
    logic              q_push, q_pop, q_full, q_empty;
    logic              div_start, div_done;
    logic [WIN_W-1:0]  div_num, div_den;
    logic [QUOT_W-1:0] div_quot;

    // The register file takes a write in every cycle; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RANGE_START:     cfg_next.range_start     = cfg_data[ID_W-1:0];
                CFG_RANGE_END:       cfg_next.range_end       = cfg_data[ID_W-1:0];
                CFG_FADE_IN_FRAMES:  cfg_next.fade_in_frames  = cfg_data[WIN_W-1:0];
                CFG_FADE_OUT_FRAMES: cfg_next.fade_out_frames = cfg_data[WIN_W-1:0];
                CFG_YUV_MODE:        cfg_next.yuv_mode        = cfg_data[0];
                CFG_GRAY_OUT:        cfg_next.gray_out        = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_start     <= '0;
            cfg_reg.range_end       <= '1;
            cfg_reg.fade_in_frames  <= '0;
            cfg_reg.fade_out_frames <= '0;
            cfg_reg.yuv_mode        <= 1'b0;
            cfg_reg.gray_out        <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: registers each input item and classifies it into the queue.
    loab_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    loab_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    // The fade factor is floor(num * 2^16 / den) with num no larger than den.
    loab_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Back end: keeps the frame state and produces one result per item.
    loab_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .div_start (div_start),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_done  (div_done),
        .div_quot  (div_quot),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
